FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL; define NO_ASSERTIONS to leave them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Antecedent at one edge implies consequent at the same edge.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/hct_pkg.sv
`timescale 1ns / 1ps

package hct_pkg;

  // Table depth; kept a power of two so the home slot is the low hash bits.
  localparam int TABLE_SIZE = 32;
  localparam int IDX_W      = $clog2(TABLE_SIZE);

  localparam int HASH_W = 32;
  localparam int CHAR_W = 8;
  localparam int ARG_W  = 32;
  localparam int SLOT_W = 5;
  localparam int ACT_W  = 2;

  localparam logic [HASH_W-1:0] HASH_MUL = 32'd131;

  localparam logic REQ_REGISTER = 1'b0;
  localparam logic REQ_LOOKUP   = 1'b1;

  localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CALL  = 2'd2;

  typedef struct packed {
    logic              has_callback;
    logic              has_target;
    logic [HASH_W-1:0] hash;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HOME_RD,
    S_HOME_CHK,
    S_RSCAN,
    S_LSCAN_RD,
    S_LSCAN_CHK,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    RES_FAIL,
    RES_REG_HOME,
    RES_REG_SCAN,
    RES_LOOK_HOME,
    RES_LOOK_SCAN
  } res_kind_t;

  typedef struct packed {
    logic      hash_upd;
    logic      latch;
    logic      rd_home;
    logic      rd_scan;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      wr_home;
    logic      wr_scan;
    logic      res_load;
    res_kind_t res_kind;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic req_lookup;
    logic home_occ;
    logic home_match;
    logic scan_free;
    logic scan_match;
    logic scan_end;
    logic out_busy;
  } status_t;

endpackage

FILE: hdl/hct_ram.sv
`timescale 1ns / 1ps

module hct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/hct_ctrl.sv
`timescale 1ns / 1ps

module hct_ctrl
  import hct_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_last,
  output logic    in_ready,
  input  status_t stat,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.res_kind = RES_FAIL;
    in_ready     = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.hash_upd = 1'b1;
          if (in_last) begin
            cmd.latch  = 1'b1;
            state_next = S_HOME_RD;
          end
        end
      end
      S_HOME_RD: begin
        cmd.rd_home = 1'b1;
        state_next  = S_HOME_CHK;
      end
      S_HOME_CHK: begin
        if (stat.req_lookup) begin
          priority if (!stat.home_occ) begin
            cmd.res_load = 1'b1;
            cmd.res_kind = RES_FAIL;
            state_next   = S_OUT;
          end else if (stat.home_match) begin
            cmd.res_load = 1'b1;
            cmd.res_kind = RES_LOOK_HOME;
            state_next   = S_OUT;
          end else begin
            cmd.cnt_clr = 1'b1;
            state_next  = S_LSCAN_RD;
          end
        end else begin
          if (!stat.home_occ) begin
            cmd.wr_home  = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_kind = RES_REG_HOME;
            state_next   = S_OUT;
          end else begin
            cmd.cnt_clr = 1'b1;
            state_next  = S_RSCAN;
          end
        end
      end
      S_RSCAN: begin
        priority if (stat.scan_free) begin
          cmd.wr_scan  = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_REG_SCAN;
          state_next   = S_OUT;
        end else if (stat.scan_end) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_FAIL;
          state_next   = S_OUT;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_LSCAN_RD: begin
        cmd.rd_scan = 1'b1;
        state_next  = S_LSCAN_CHK;
      end
      S_LSCAN_CHK: begin
        priority if (stat.scan_match) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_LOOK_SCAN;
          state_next   = S_OUT;
        end else if (stat.scan_end) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_FAIL;
          state_next   = S_OUT;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_next  = S_LSCAN_RD;
        end
      end
      S_OUT: begin
        // hold the result until the output register is free
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/hct_dp.sv
`timescale 1ns / 1ps

module hct_dp
  import hct_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_type,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              has_target,
  input  logic              has_callback,
  input  logic [ARG_W-1:0]  arg_value,
  input  cmd_t              cmd,
  output status_t           stat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              ok,
  output logic [SLOT_W-1:0] slot,
  output logic [ACT_W-1:0]  action,
  output logic [ARG_W-1:0]  write_value
);

  logic [HASH_W-1:0]     hash, hash_next;
  logic [HASH_W-1:0]     req_hash;
  logic                  req_lookup;
  logic                  req_tgt;
  logic                  req_cb;
  logic [ARG_W-1:0]      req_arg;
  logic [TABLE_SIZE-1:0] occ;
  logic [IDX_W-1:0]      cnt;
  logic [IDX_W-1:0]      home;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic                  ram_re;
  logic [IDX_W-1:0]      ram_raddr;
  entry_t                ram_wdata;
  entry_t                ram_rdata;
  logic [HASH_W-1:0]     scan_hash;

  logic                  res_ok, res_ok_next;
  logic [SLOT_W-1:0]     res_slot, res_slot_next;
  logic [ACT_W-1:0]      res_act, res_act_next;
  logic [ARG_W-1:0]      res_value, res_value_next;
  logic                  look_occ;
  logic [IDX_W-1:0]      look_idx;

  // rolling hash: hash * 131 + char, a zero character leaves it unchanged
  assign hash_next = (char_code != '0) ?
                     HASH_W'(hash * HASH_MUL) + HASH_W'(char_code) : hash;

  assign home = req_hash[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= '0;
    end else if (cmd.latch) begin
      hash <= '0;
    end else if (cmd.hash_upd) begin
      hash <= hash_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_hash   <= hash_next;
      req_lookup <= (req_type == REQ_LOOKUP);
      req_tgt    <= has_target;
      req_cb     <= has_callback;
      req_arg    <= arg_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (cmd.wr_home) begin
      occ[home] <= 1'b1;
    end else if (cmd.wr_scan) begin
      occ[cnt] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign ram_we    = cmd.wr_home | cmd.wr_scan;
  assign ram_waddr = cmd.wr_home ? home : cnt;
  assign ram_wdata = '{has_callback: req_cb, has_target: req_tgt, hash: req_hash};
  assign ram_re    = cmd.rd_home | cmd.rd_scan;
  assign ram_raddr = cmd.rd_home ? home : cnt;

  hct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SIZE)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // a free entry reads as hash zero
  assign scan_hash = occ[cnt] ? ram_rdata.hash : '0;

  assign stat.req_lookup = req_lookup;
  assign stat.home_occ   = occ[home];
  assign stat.home_match = (ram_rdata.hash == req_hash);
  assign stat.scan_free  = !occ[cnt];
  assign stat.scan_match = (scan_hash == req_hash);
  assign stat.scan_end   = (cnt == IDX_W'(TABLE_SIZE - 1));
  assign stat.out_busy   = out_valid & ~out_ready;

  assign look_occ = (cmd.res_kind == RES_LOOK_HOME) ? 1'b1 : occ[cnt];
  assign look_idx = (cmd.res_kind == RES_LOOK_HOME) ? home : cnt;

  always_comb begin
    res_ok_next    = 1'b0;
    res_slot_next  = '0;
    res_act_next   = ACT_NONE;
    res_value_next = '0;
    unique case (cmd.res_kind)
      RES_FAIL: begin
      end
      RES_REG_HOME: begin
        res_ok_next   = 1'b1;
        res_slot_next = SLOT_W'(home);
      end
      RES_REG_SCAN: begin
        res_ok_next   = 1'b1;
        res_slot_next = SLOT_W'(cnt);
      end
      RES_LOOK_HOME, RES_LOOK_SCAN: begin
        // target write wins over callback; an entry with neither fails
        if (look_occ && ram_rdata.has_target) begin
          res_ok_next    = 1'b1;
          res_slot_next  = SLOT_W'(look_idx);
          res_act_next   = ACT_WRITE;
          res_value_next = req_arg;
        end else if (look_occ && ram_rdata.has_callback) begin
          res_ok_next   = 1'b1;
          res_slot_next = SLOT_W'(look_idx);
          res_act_next  = ACT_CALL;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_ok    <= res_ok_next;
      res_slot  <= res_slot_next;
      res_act   <= res_act_next;
      res_value <= res_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ok          <= res_ok;
      slot        <= res_slot;
      action      <= res_act;
      write_value <= res_value;
    end
  end

endmodule

FILE: hdl/hashed_command_table_unit.sv
`timescale 1ns / 1ps
// Command table addressed by a 32-bit rolling hash (hash * 131 + char). Each
// character item is taken while the controller is idle and gives no result.
// The item marked last registers or looks up the name and gives one result:
// with the home slot usable it goes through accept, entry read, check and
// output load; a busy home slot starts a scan from entry 0, one entry a cycle
// for a registration, which tests only the occupancy bits, and a read then a
// check for each entry for a lookup, as the entry memory's read is registered.
// The table is empty straight after reset. A finished result waits in the
// output register while the next name's characters are taken.

`include "assert_macros.svh"

module hashed_command_table_unit
  import hct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] char_code, [8] has_target, [9] has_callback, [41:10] arg_value
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  // [0] req_type
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] ok, [5:1] slot, [7:6] action, [39:8] write_value
  output logic [39:0] m_axis_tdata
);

  cmd_t              cmd;
  status_t           stat;
  logic              ok;
  logic [SLOT_W-1:0] slot;
  logic [ACT_W-1:0]  action;
  logic [ARG_W-1:0]  write_value;

  hct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hct_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .req_type     (s_axis_tuser),
    .char_code    (s_axis_tdata[7:0]),
    .has_target   (s_axis_tdata[8]),
    .has_callback (s_axis_tdata[9]),
    .arg_value    (s_axis_tdata[41:10]),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .ok           (ok),
    .slot         (slot),
    .action       (action),
    .write_value  (write_value)
  );

  assign m_axis_tdata = {write_value, action, slot, ok};

  `ASSERT_IMPLY(a_no_res_while_ready, clk, rst, s_axis_tready, !cmd.res_load)
  `ASSERT_IMPLY(a_home_write_free, clk, rst, cmd.wr_home, !stat.home_occ)
  `ASSERT_IMPLY(a_scan_write_free, clk, rst, cmd.wr_scan, stat.scan_free)
  `ASSERT_ALWAYS(a_out_load_free, clk, rst, !(cmd.out_load && stat.out_busy))

endmodule
